// ===== hw/rtl/dsi_pkg.sv =====
`timescale 1ns / 1ps
// dsi_pkg: shared types, phase codes and constants for the decimal string
// to int64 parser. No dependencies.
package dsi_pkg;

   localparam int CharWidth  = 8;
   localparam int ValueWidth = 64;
   localparam int PhaseWidth = 3;

   localparam logic [PhaseWidth-1:0] PH_LEAD   = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_SIGN   = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_DIGITS = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_TRAIL  = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_BAD    = 3'd4;

   localparam logic [ValueWidth-1:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

   localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;
   localparam logic [CharWidth-1:0] CH_TAB   = 8'h09;
   localparam logic [CharWidth-1:0] CH_CR    = 8'h0D;
   localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;
   localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;

   // running parse state; mag_neg tracks the two's complement of mag
   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [ValueWidth-1:0] mag;
      logic [ValueWidth-1:0] mag_neg;
      logic                  negative;
      logic                  overflow;
      logic                  missing;
      logic                  any_char;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:    PH_LEAD,
      mag:      '0,
      mag_neg:  '0,
      negative: 1'b0,
      overflow: 1'b0,
      missing:  1'b0,
      any_char: 1'b0
   };

endpackage

// ===== hw/rtl/dsi_if.sv =====
`timescale 1ns / 1ps
// dsi_req_if / dsi_rsp_if: valid/ready channels for character words in and
// parsed results out. Depends on dsi_pkg.
interface dsi_req_if;
   logic                           valid;
   logic                           ready;
   logic [dsi_pkg::CharWidth-1:0]  char_byte;
   logic                           has_char;
   logic                           end_of_string;
   logic                           missing_string;

   modport source (output valid, char_byte, has_char, end_of_string, missing_string,
                   input ready);
   modport sink   (input valid, char_byte, has_char, end_of_string, missing_string,
                   output ready);
endinterface

interface dsi_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dsi_pkg::ValueWidth-1:0] value;
   logic                                is_na;

   modport source (output valid, value, is_na, input ready);
   modport sink   (input valid, value, is_na, output ready);
endinterface

// ===== hw/rtl/dsi_char_step.sv =====
`timescale 1ns / 1ps
// dsi_char_step: next parse state from the current state and one character
// word. Combinational. Depends on dsi_pkg.
module dsi_char_step (
   input  dsi_pkg::parse_state_type        state,
   input  logic [dsi_pkg::CharWidth-1:0]   char_byte,
   input  logic                            has_char,
   input  logic                            missing_string,
   output dsi_pkg::parse_state_type        state_next
);
   import dsi_pkg::*;

   logic                   is_ws;
   logic                   is_digit;
   logic                   is_sign;
   logic [3:0]             digit;
   logic [ValueWidth+3:0]  mag_times_ten;
   logic [ValueWidth-1:0]  neg_times_ten;
   logic                   digit_ovf;
   parse_state_type        after_digit;

   assign is_ws    = (char_byte == CH_SPACE) || (char_byte >= CH_TAB && char_byte <= CH_CR);
   assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
   assign is_sign  = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
   assign digit    = 4'(char_byte - CH_ZERO);

   // mag * 10 + d, with headroom to detect going past 2^63
   assign mag_times_ten = ({4'b0, state.mag} << 3) + ({4'b0, state.mag} << 1)
                        + {{ValueWidth{1'b0}}, digit};
   assign neg_times_ten = (state.mag_neg << 3) + (state.mag_neg << 1)
                        - {{(ValueWidth-4){1'b0}}, digit};
   assign digit_ovf     = mag_times_ten > {4'b0, MAG_LIMIT};

   always_comb begin
      after_digit = state;
      after_digit.phase = PH_DIGITS;
      if (!state.overflow) begin
         if (digit_ovf) begin
            after_digit.overflow = 1'b1;
            after_digit.mag      = MAG_LIMIT;
            after_digit.mag_neg  = MAG_LIMIT;
         end else begin
            after_digit.mag     = mag_times_ten[ValueWidth-1:0];
            after_digit.mag_neg = neg_times_ten;
         end
      end
   end

   always_comb begin
      state_next = state;
      if (missing_string) begin
         state_next.missing = 1'b1;
      end
      if (has_char) begin
         state_next.any_char = 1'b1;
         case (state.phase)
            PH_LEAD: begin
               if (is_ws) begin
                  state_next.phase = PH_LEAD;
               end else if (is_sign) begin
                  state_next.phase    = PH_SIGN;
                  state_next.negative = (char_byte == CH_MINUS);
               end else if (is_digit) begin
                  state_next.phase    = after_digit.phase;
                  state_next.mag      = after_digit.mag;
                  state_next.mag_neg  = after_digit.mag_neg;
                  state_next.overflow = after_digit.overflow;
               end else begin
                  state_next.phase = PH_BAD;
               end
            end
            PH_SIGN, PH_DIGITS: begin
               if (is_digit) begin
                  state_next.phase    = after_digit.phase;
                  state_next.mag      = after_digit.mag;
                  state_next.mag_neg  = after_digit.mag_neg;
                  state_next.overflow = after_digit.overflow;
               end else if (state.phase == PH_DIGITS && is_ws) begin
                  state_next.phase = PH_TRAIL;
               end else begin
                  state_next.phase = PH_BAD;
               end
            end
            PH_TRAIL: begin
               if (!is_ws) begin
                  state_next.phase = PH_BAD;
               end
            end
            default: begin
               state_next.phase = PH_BAD;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/dsi_format.sv =====
`timescale 1ns / 1ps
// dsi_format: turns the final parse state of a string into value and NA flag.
// Combinational. Depends on dsi_pkg.
module dsi_format (
   input  dsi_pkg::parse_state_type              state,
   output logic signed [dsi_pkg::ValueWidth-1:0] value,
   output logic                                  is_na
);
   import dsi_pkg::*;

   logic phase_ok;

   assign phase_ok = (state.phase == PH_DIGITS) || (state.phase == PH_TRAIL);

   always_comb begin
      is_na = 1'b0;
      value = '0;
      if (state.missing) begin
         is_na = 1'b1;
      end else if (!state.any_char) begin
         is_na = 1'b0;
      end else if (!phase_ok || state.overflow) begin
         is_na = 1'b1;
      end else if (state.negative) begin
         value = signed'(state.mag_neg);
      end else if (state.mag[ValueWidth-1]) begin
         is_na = 1'b1;
      end else begin
         value = signed'(state.mag);
      end
      if (is_na) begin
         value = signed'(MAG_LIMIT);
      end
   end

endmodule

// ===== hw/rtl/decimal_string_to_int64.sv =====
`timescale 1ns / 1ps
// Depends on dsi_pkg, dsi_if, dsi_char_step, dsi_format. Throughput: one
// character word per cycle; an end word waits in the input register while
// the previous result is still held in the output register.
// Reset (synchronous, active high): channels empty, parse state back to
// leading whitespace with a zero magnitude.
module decimal_string_to_int64 (
   input  logic       clock,
   input  logic       reset,
   dsi_req_if.sink    req_chan,
   dsi_rsp_if.source  rsp_chan
);
   import dsi_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [CharWidth-1:0]  in_char_ff;
   logic                  in_has_ff;
   logic                  in_end_ff;
   logic                  in_miss_ff;

   parse_state_type       state_ff, state_in, step_next;

   logic                  out_valid_ff, out_valid_in;
   logic signed [ValueWidth-1:0] out_value_ff;
   logic                  out_na_ff;
   logic signed [ValueWidth-1:0] fmt_value;
   logic                  fmt_na;

   logic                  stall;
   logic                  advance;
   logic                  accept;

   assign stall   = out_valid_ff && !rsp_chan.ready;
   assign advance = in_valid_ff && !(in_end_ff && stall);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept  = req_chan.valid && req_chan.ready;

   dsi_char_step u_step (
      .state          (state_ff),
      .char_byte      (in_char_ff),
      .has_char       (in_has_ff),
      .missing_string (in_miss_ff),
      .state_next     (step_next)
   );

   dsi_format u_format (
      .state (step_next),
      .value (fmt_value),
      .is_na (fmt_na)
   );

   always_comb begin
      in_valid_in = req_chan.ready ? req_chan.valid : in_valid_ff;
      state_in    = state_ff;
      if (advance) begin
         state_in = in_end_ff ? STATE_RESET : step_next;
      end
      out_valid_in = out_valid_ff;
      if (advance && in_end_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_chan.char_byte;
         in_has_ff  <= req_chan.has_char;
         in_end_ff  <= req_chan.end_of_string;
         in_miss_ff <= req_chan.missing_string;
      end
      if (advance && in_end_ff) begin
         out_value_ff <= fmt_value;
         out_na_ff    <= fmt_na;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.value = out_value_ff;
   assign rsp_chan.is_na = out_na_ff;

endmodule

// ===== hw/rtl/dsi_checker.sv =====
`timescale 1ns / 1ps
// dsi_checker: port-level checks on the parser's channels, bound to the top
// level. Depends on dsi_pkg.
module dsi_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [dsi_pkg::ValueWidth-1:0] rsp_value,
   input logic                                  rsp_is_na
);
   import dsi_pkg::*;

   // NA words always carry the most negative value
   a_na_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_na |-> rsp_value == signed'(MAG_LIMIT))
      else $error("NA word without INT64_MIN value");

   // input only backs up when a result is stuck at the output
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with free output");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_is_na))
      else $error("stalled result word changed");

endmodule

bind decimal_string_to_int64 dsi_checker u_dsi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.value),
   .rsp_is_na (rsp_chan.is_na)
);

// ===== bench/tb_decimal_string_to_int64.sv =====
`timescale 1ns / 1ps
// tb_decimal_string_to_int64: self-checking bench for the decimal string to int64
// parser. Strings go in one character word at a time and each result is checked
// against a local parser model. Depends on dsi_pkg, dsi_if, decimal_string_to_int64.
module tb_decimal_string_to_int64;
   import dsi_pkg::*;

   typedef logic [CharWidth-1:0] char_queue_type[$];

   typedef struct {
      logic signed [ValueWidth-1:0] value;
      logic                         is_na;
   } int64_result_type;

   localparam int WordTarget = 1650;
   localparam int MaxReports = 50;

   logic clock;
   logic reset;
   bit   no_idle;

   dsi_req_if req_chan();
   dsi_rsp_if rsp_chan();

   decimal_string_to_int64 i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // parser model state
   logic [PhaseWidth-1:0] prs_phase;
   logic [ValueWidth-1:0] prs_mag;
   logic                  prs_neg;
   logic                  prs_ovf;
   logic                  prs_missing;
   logic                  prs_any;

   int64_result_type expected_values[$];
   int word_count;
   int string_count;
   int result_count;
   int na_count;
   int error_count;

   function automatic void clear_parse();
      prs_phase   = PH_LEAD;
      prs_mag     = '0;
      prs_neg     = 1'b0;
      prs_ovf     = 1'b0;
      prs_missing = 1'b0;
      prs_any     = 1'b0;
   endfunction

   function automatic logic is_space(logic [CharWidth-1:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void push_digit(logic [CharWidth-1:0] c);
      logic [ValueWidth-1:0] d;
      d = {56'd0, c - CH_ZERO};
      if (prs_ovf) return;
      if (prs_mag > (MAG_LIMIT - d) / 10) begin
         prs_ovf = 1'b1;
         prs_mag = MAG_LIMIT;
      end else begin
         prs_mag = prs_mag * 10 + d;
      end
   endfunction

   function automatic void take_char(logic [CharWidth-1:0] c);
      logic digit;
      digit   = (c >= CH_ZERO && c <= CH_NINE);
      prs_any = 1'b1;
      case (prs_phase)
         PH_LEAD: begin
            if (!is_space(c)) begin
               if (c == CH_PLUS || c == CH_MINUS) begin
                  prs_neg   = (c == CH_MINUS);
                  prs_phase = PH_SIGN;
               end else if (digit) begin
                  push_digit(c);
                  prs_phase = PH_DIGITS;
               end else begin
                  prs_phase = PH_BAD;
               end
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (digit) begin
               push_digit(c);
               prs_phase = PH_DIGITS;
            end else if (prs_phase == PH_DIGITS && is_space(c)) begin
               prs_phase = PH_TRAIL;
            end else begin
               prs_phase = PH_BAD;
            end
         end
         PH_TRAIL: begin
            if (!is_space(c)) prs_phase = PH_BAD;
         end
         default: prs_phase = PH_BAD;
      endcase
   endfunction

   // advances the model by one word; got is set on a string's end word
   function automatic void parse_word(input logic [CharWidth-1:0] ch, input logic has,
                                      input logic eos, input logic miss,
                                      output logic got, output int64_result_type res);
      logic                  na;
      logic [ValueWidth-1:0] val;
      got = 1'b0;
      res.value = '0;
      res.is_na = 1'b0;
      if (miss) prs_missing = 1'b1;
      if (has) take_char(ch);
      if (!eos) return;
      got = 1'b1;
      na  = 1'b0;
      val = '0;
      if (prs_missing) begin
         na = 1'b1;
      end else if (!prs_any) begin
         val = '0;
      end else if (prs_phase != PH_DIGITS && prs_phase != PH_TRAIL) begin
         na = 1'b1;
      end else if (prs_ovf) begin
         na = 1'b1;
      end else if (prs_neg) begin
         val = '0 - prs_mag;
      end else if (prs_mag >= MAG_LIMIT) begin
         na = 1'b1;
      end else begin
         val = prs_mag;
      end
      res.value = na ? MAG_LIMIT : val;
      res.is_na = na;
      clear_parse();
   endfunction

   function automatic logic [CharWidth-1:0] pick_space();
      if ($urandom_range(0, 5) == 5) return CH_SPACE;
      return CH_TAB + 8'($urandom_range(0, 4));
   endfunction

   function automatic logic [CharWidth-1:0] pick_sign();
      return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
   endfunction

   function automatic logic [CharWidth-1:0] pick_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return pick_space();
         2: return pick_sign();
         default: return CH_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   function automatic char_queue_type to_chars(string s);
      char_queue_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // well-formed number with random padding, sign and magnitude
   function automatic char_queue_type build_number();
      char_queue_type q;
      string digits;
      logic [ValueWidth-1:0] v;
      digits = "";
      repeat ($urandom_range(0, 3)) q.push_back(pick_space());
      case ($urandom_range(0, 2))
         1: q.push_back(CH_PLUS);
         2: q.push_back(CH_MINUS);
         default: ;
      endcase
      case ($urandom_range(0, 4))
         0: begin
            v = {$urandom, $urandom};
            digits = $sformatf("%0d", v);
         end
         1: begin
            v = MAG_LIMIT + 64'($urandom_range(0, 6)) - 64'd3;
            digits = $sformatf("%0d", v);
         end
         2: digits = $sformatf("%0d", $urandom_range(0, 999));
         3: repeat ($urandom_range(1, 24)) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         default: digits = $sformatf("%0d", $urandom);
      endcase
      for (int i = 0; i < digits.len(); i++) q.push_back(digits[i]);
      repeat ($urandom_range(0, 2)) q.push_back(pick_space());
      return q;
   endfunction

   task automatic send_word(input logic [CharWidth-1:0] ch, input logic has,
                            input logic eos, input logic miss);
      int gap;
      logic got;
      int64_result_type res;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid          <= 1'b1;
      req_chan.char_byte      <= ch;
      req_chan.has_char       <= has;
      req_chan.end_of_string  <= eos;
      req_chan.missing_string <= miss;
      do @(posedge clock); while (!req_chan.ready);
      parse_word(ch, has, eos, miss, got, res);
      if (got) begin
         expected_values.push_back(res);
         string_count++;
      end
      word_count++;
   endtask

   // miss_pos marks the word carrying missing_string; chars.size() means the end word
   task automatic send_chars(input char_queue_type chars, input int miss_pos,
                             input bit end_alone, input bit fillers);
      int n;
      bit alone;
      n = chars.size();
      alone = end_alone || n == 0 || miss_pos == n;
      for (int i = 0; i < n; i++) begin
         if (fillers && $urandom_range(0, 3) == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, $urandom_range(0, 15) == 0);
         send_word(chars[i], 1'b1, !alone && i == n - 1, i == miss_pos);
      end
      if (alone) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, miss_pos == n);
   endtask

   task automatic test_directed();
      char_queue_type q;
      send_chars(to_chars("0"), -1, 0, 0);
      send_chars(to_chars("+0"), -1, 0, 0);
      send_chars(to_chars("-0"), -1, 1, 0);
      send_chars(to_chars("007"), -1, 0, 0);
      send_chars(to_chars("9223372036854775807"), -1, 0, 0);
      send_chars(to_chars("-9223372036854775808"), -1, 0, 0);
      send_chars(to_chars("9223372036854775808"), -1, 0, 0);
      send_chars(to_chars("-9223372036854775809"), -1, 1, 0);
      send_chars(to_chars("123456789012345678901234"), -1, 0, 0);
      send_chars(to_chars(""), -1, 1, 0);
      send_chars(to_chars(" \t\n-42 \t\r"), -1, 0, 0);
      send_chars(to_chars("  "), -1, 0, 0);
      send_chars(to_chars("+"), -1, 0, 0);
      send_chars(to_chars("-"), -1, 1, 0);
      send_chars(to_chars("12a"), -1, 0, 0);
      send_chars(to_chars("a12"), -1, 0, 0);
      send_chars(to_chars("1 2"), -1, 0, 0);
      send_chars(to_chars("+-1"), -1, 0, 0);
      send_chars(to_chars("/:"), -1, 0, 0);
      q = to_chars("1");
      q.push_back(8'h00);
      send_chars(q, -1, 0, 0);
      q = to_chars("3");
      q.push_back(8'hFF);
      send_chars(q, -1, 1, 0);
      q = {8'h0B, 8'h0C};
      q.push_back(8'h35);
      send_chars(q, -1, 0, 0);
      send_chars(to_chars("55"), 0, 0, 0);
      send_chars(to_chars("7"), 1, 1, 0);
      send_chars(to_chars(""), 0, 1, 0);
      send_word(8'hA5, 1'b0, 1'b0, 1'b1);
      send_chars(to_chars("5"), -1, 0, 0);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (40) send_chars(build_number(), -1, $urandom_range(0, 1), 0);
      no_idle = 1'b0;
   endtask

   task automatic test_random_mix();
      char_queue_type q;
      int kind;
      int idx;
      int miss_pos;
      while (word_count < WordTarget) begin
         kind = $urandom_range(0, 9);
         q = {};
         if (kind <= 6) begin
            q = build_number();
         end else if (kind == 7) begin
            q = build_number();
            idx = $urandom_range(0, q.size() - 1);
            if ($urandom_range(0, 1)) q[idx] = pick_char();
            else q.insert(idx, pick_char());
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 6)) q.push_back(pick_char());
         end else begin
            repeat ($urandom_range(0, 3))
               q.push_back($urandom_range(0, 1) ? pick_space() : pick_sign());
         end
         miss_pos = ($urandom_range(0, 15) == 0) ? $urandom_range(0, q.size()) : -1;
         send_chars(q, miss_pos, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: random stalls, then compare against the oldest expectation
   initial begin
      int stall;
      int64_result_type exp_res;
      wait (reset == 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         result_count++;
         if (rsp_chan.is_na) na_count++;
         if (expected_values.size() == 0) begin
            error_count++;
            if (error_count <= MaxReports)
               $display("%0t unexpected word: value %0d is_na %0b", $time,
                        rsp_chan.value, rsp_chan.is_na);
         end else begin
            exp_res = expected_values.pop_front();
            if (rsp_chan.value !== exp_res.value) begin
               error_count++;
               if (error_count <= MaxReports)
                  $display("%0t value mismatch: expected %0d actual %0d", $time,
                           exp_res.value, rsp_chan.value);
            end
            if (rsp_chan.is_na !== exp_res.is_na) begin
               error_count++;
               if (error_count <= MaxReports)
                  $display("%0t is_na mismatch: expected %0b actual %0b", $time,
                           exp_res.is_na, rsp_chan.is_na);
            end
         end
      end
   end

   initial begin
      reset                   = 1'b1;
      no_idle                 = 1'b0;
      req_chan.valid          = 1'b0;
      req_chan.char_byte      = '0;
      req_chan.has_char       = 1'b0;
      req_chan.end_of_string  = 1'b0;
      req_chan.missing_string = 1'b0;
      rsp_chan.ready          = 1'b0;
      word_count   = 0;
      string_count = 0;
      result_count = 0;
      na_count     = 0;
      error_count  = 0;
      clear_parse();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_back_to_back();
      test_random_mix();

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_values.size() != 0) begin
         error_count++;
         $display("%0t missing words: expected %0d more results, actual none", $time,
                  expected_values.size());
      end

      $display("Parsed %0d strings from %0d words: %0d results checked, %0d of them NA.",
               string_count, word_count, result_count, na_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== decimal_string_to_int64.f =====
hw/rtl/dsi_pkg.sv
hw/rtl/dsi_if.sv
hw/rtl/dsi_char_step.sv
hw/rtl/dsi_format.sv
hw/rtl/decimal_string_to_int64.sv
hw/rtl/dsi_checker.sv
bench/tb_decimal_string_to_int64.sv
